// ===== sv/balrs_pkg.sv =====
// balrs_pkg: types and constants for the bar level attack/release smoother.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package balrs_pkg;

  // input command codes
  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SENSITIVITY   = 2'd0;
  localparam logic [1:0] REG_RISE_SPEED    = 2'd1;
  localparam logic [1:0] REG_RELEASE_SPEED = 2'd2;
  localparam logic [1:0] REG_ACTIVE_BARS   = 2'd3;

  localparam logic [15:0] SENS_RESET   = 16'd256;
  localparam logic [6:0]  SPEED_RESET  = 7'd50;
  localparam logic [6:0]  ACTIVE_RESET = 7'd64;
  localparam logic [6:0]  SPEED_MIN    = 7'd1;
  localparam logic [6:0]  SPEED_MAX    = 7'd100;

  // x / 100 == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^23
  localparam logic [23:0] RECIP_MUL   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WRITE
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div;
    logic write;
  } dp_cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_bar_ok;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/balrs_in_if.sv =====
// balrs_in_if: input channel, valid/ready with one sample item.
// No dependencies.
`timescale 1ns / 1ps

interface balrs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  bar_index;
  logic [15:0] sample;

  modport source (output valid, output command, output bar_index, output sample,
                  input ready);
  modport sink   (input valid, input command, input bar_index, input sample,
                  output ready);
endinterface

// ===== sv/balrs_out_if.sv =====
// balrs_out_if: result channel, valid/ready with one smoothed level.
// No dependencies.
`timescale 1ns / 1ps

interface balrs_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  out_bar;
  logic [15:0] level;
  logic        frame_end;

  modport source (output valid, output out_bar, output level, output frame_end,
                  input ready);
  modport sink   (input valid, input out_bar, input level, input frame_end,
                  output ready);
endinterface

// ===== sv/balrs_ctrl.sv =====
// balrs_ctrl: sequencing state machine for the smoother datapath.
// Depends on balrs_pkg.
`timescale 1ns / 1ps

module balrs_ctrl
  import balrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && !status_i.in_clear && status_i.in_bar_ok) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/balrs_dp.sv =====
// balrs_dp: level memory, valid bits, scaling and attack/release arithmetic,
// output register. Depends on balrs_pkg; driven by balrs_ctrl.
`timescale 1ns / 1ps

module balrs_dp
  import balrs_pkg::*;
#(
  parameter int MAX_BARS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  logic        in_command_i,
  input  logic [5:0]  in_bar_index_i,
  input  logic [15:0] in_sample_i,
  input  logic [15:0] sensitivity_i,
  input  logic [6:0]  rise_speed_i,
  input  logic [6:0]  release_speed_i,
  input  logic [6:0]  active_bars_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  out_bar_o,
  output logic [15:0] out_level_o,
  output logic        out_frame_end_o
);

  localparam int IDX_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;

  logic [15:0] mem [MAX_BARS];
  logic [MAX_BARS-1:0] valid_q;

  logic [8:0]       in_bar_ext;
  logic [IDX_W-1:0] in_idx;
  logic [8:0]       bar_ext_q;
  logic [IDX_W-1:0] bar_idx;

  logic [5:0]  bar_q;
  logic [31:0] prod_q;
  logic [15:0] rd_q;
  logic        vld_q;
  logic [15:0] cur_q;
  logic        up_q;
  logic [22:0] dprod_q;
  logic [46:0] qprod_q;

  logic [15:0] scaled;
  logic [15:0] cur;
  logic        up;
  logic [15:0] delta;
  logic [6:0]  speed;
  logic [15:0] quot;
  logic [15:0] next_level;

  logic        out_valid_q;
  logic [5:0]  out_bar_q;
  logic [15:0] out_level_q;
  logic        out_fe_q;

  function automatic logic [6:0] clamp_speed(input logic [6:0] s);
    if (s < SPEED_MIN) begin
      return SPEED_MIN;
    end else if (s > SPEED_MAX) begin
      return SPEED_MAX;
    end
    return s;
  endfunction

  assign in_bar_ext = {3'b000, in_bar_index_i};
  assign in_idx     = in_bar_ext[IDX_W-1:0];
  assign bar_ext_q  = {3'b000, bar_q};
  assign bar_idx    = bar_ext_q[IDX_W-1:0];

  assign status_o.in_clear  = (in_command_i == CMD_CLEAR);
  assign status_o.in_bar_ok = (in_bar_ext < 9'(MAX_BARS));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  // stage math
  assign scaled = (prod_q[31:24] != 8'd0) ? 16'hFFFF : prod_q[23:8];
  assign cur    = vld_q ? rd_q : 16'd0;
  assign up     = scaled > cur;
  assign delta  = up ? (scaled - cur) : (cur - scaled);
  assign speed  = clamp_speed(up ? rise_speed_i : release_speed_i);
  assign quot   = qprod_q[RECIP_SHIFT+15:RECIP_SHIFT];
  assign next_level = up_q ? (cur_q + quot) : (cur_q - quot);

  // level memory, read at accept, written at the end of the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= mem[in_idx];
    end
    if (cmd_i.write) begin
      mem[bar_idx] <= next_level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.accept && status_o.in_clear) begin
      valid_q <= '0;
    end else if (cmd_i.write) begin
      valid_q[bar_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      bar_q  <= in_bar_index_i;
      prod_q <= {16'd0, in_sample_i} * {16'd0, sensitivity_i};
      vld_q  <= valid_q[in_idx];
    end
    if (cmd_i.mul) begin
      cur_q   <= cur;
      up_q    <= up;
      dprod_q <= {7'd0, delta} * {16'd0, speed};
    end
    if (cmd_i.div) begin
      qprod_q <= {24'd0, dprod_q} * {23'd0, RECIP_MUL};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      out_bar_q   <= bar_q;
      out_level_q <= next_level;
      out_fe_q    <= (({1'b0, bar_q} + 7'd1) == active_bars_i);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_bar_o       = out_bar_q;
  assign out_level_o     = out_level_q;
  assign out_frame_end_o = out_fe_q;

endmodule

// ===== sv/bar_level_attack_release_smoother_unit.sv =====
// bar_level_attack_release_smoother_unit: top level with APB register file.
// Depends on balrs_pkg, balrs_in_if, balrs_out_if, balrs_ctrl, balrs_dp.
`timescale 1ns / 1ps

// Per-bar attack/release level smoother. An update item (bar, magnitude) is
// scaled by the Q8.8 sensitivity, saturated to 16 bits, and the bar's stored
// level moves toward it by gap*speed/100 (rise or release speed). One item is
// in flight at a time: an update passes through the memory read, the speed
// multiply and the divide-by-100 multiply, then waits in the write step while
// the previous result still waits at the output; its result is presented and
// the input reopens in the same cycle. A clear command or a bar at or beyond
// MAX_BARS is taken in the idle state and gives no result.
// Registers (APB, 4-byte stride): 0 sensitivity, 1 rise_speed,
// 2 release_speed, 3 active_bars; write them only while the block is idle.

module bar_level_attack_release_smoother_unit
  import balrs_pkg::*;
#(
  parameter int MAX_BARS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  balrs_in_if.sink    in_if,
  balrs_out_if.source out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] sensitivity_q;
  logic [6:0]  rise_speed_q;
  logic [6:0]  release_speed_q;
  logic [6:0]  active_bars_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensitivity_q   <= SENS_RESET;
      rise_speed_q    <= SPEED_RESET;
      release_speed_q <= SPEED_RESET;
      active_bars_q   <= ACTIVE_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SENSITIVITY:   sensitivity_q   <= pwdata[15:0];
        REG_RISE_SPEED:    rise_speed_q    <= pwdata[6:0];
        REG_RELEASE_SPEED: release_speed_q <= pwdata[6:0];
        REG_ACTIVE_BARS:   active_bars_q   <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SENSITIVITY:   prdata = {16'd0, sensitivity_q};
      REG_RISE_SPEED:    prdata = {25'd0, rise_speed_q};
      REG_RELEASE_SPEED: prdata = {25'd0, release_speed_q};
      REG_ACTIVE_BARS:   prdata = {25'd0, active_bars_q};
      default:           prdata = 32'd0;
    endcase
  end

  balrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  balrs_dp #(
    .MAX_BARS (MAX_BARS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .in_command_i    (in_if.command),
    .in_bar_index_i  (in_if.bar_index),
    .in_sample_i     (in_if.sample),
    .sensitivity_i   (sensitivity_q),
    .rise_speed_i    (rise_speed_q),
    .release_speed_i (release_speed_q),
    .active_bars_i   (active_bars_q),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .out_bar_o       (out_if.out_bar),
    .out_level_o     (out_if.level),
    .out_frame_end_o (out_if.frame_end)
  );

  // an accepted update keeps the input closed while it is worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.command == CMD_UPDATE &&
     dp_status.in_bar_ok) |-> ##1 !in_if.ready ##1 !in_if.ready ##1 !in_if.ready)
    else $error("input reopened during an update");

  // a clear gives no result and leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready && in_if.command == CMD_CLEAR)
    |=> (in_if.ready && !$rose(out_if.valid)))
    else $error("clear produced a result or stalled");

  // a result is loaded only by the write step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(dp_cmd.write))
    else $error("result appeared without a write step");

endmodule
